### design/hcc_pkg.sv
// Package: widths, constants, command and status codes for the glyph cache.
package hcc_pkg;

    localparam int unsigned BUCKETS     = 64;
    localparam int unsigned MAX_ENTRIES = 1024;
    localparam int unsigned ENTRY_BYTES = 24;
    localparam int unsigned BKT_W       = $clog2(BUCKETS);
    localparam int unsigned ENT_W       = $clog2(MAX_ENTRIES);
    localparam int unsigned PTR_W       = ENT_W + 1;
    localparam logic [31:0] HASH_MUL    = 32'd2654435761;
    localparam logic [23:0] REC_BYTES   = 24'((ENTRY_BYTES + 3) / 4 * 4);
    localparam logic [PTR_W-1:0] NIL    = PTR_W'(MAX_ENTRIES);

    typedef enum logic [1:0] {
        CMD_LOOKUP = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_STATS  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_HIT      = 3'd0,
        ST_MISS     = 3'd1,
        ST_INSERTED = 3'd2,
        ST_PRESENT  = 3'd3,
        ST_NO_ROOM  = 3'd4,
        ST_REJECTED = 3'd5,
        ST_DONE     = 3'd6
    } t_status;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] font_id;
        logic [20:0] code_point;
        logic [7:0]  glyph_type;
        logic [15:0] header_bytes;
        logic [15:0] dot_bytes;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [23:0] data_offset;
        logic [16:0] data_len;
        logic [31:0] lookup_hits;
        logic [31:0] lookup_misses;
        logic [23:0] used_bytes;
        logic [23:0] pool_bytes;
    } t_rsp;

endpackage

### design/hcc_if.sv
// Valid/ready channel interfaces for requests, results and configuration.
interface hcc_req_if;
    import hcc_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface hcc_rsp_if;
    import hcc_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface hcc_cfg_if;
    logic        valid;
    logic        ready;
    logic [23:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/hcc_hash.sv
// Bucket hash: two partial products over the 16-bit multiplier halves, registered, then summed.
module hcc_hash (
    input  logic                  i_clk,
    input  logic                  i_start,
    input  logic [31:0]           i_font,
    input  logic [20:0]           i_code,
    input  logic [7:0]            i_type,
    output logic [hcc_pkg::BKT_W-1:0] o_bucket
);
    import hcc_pkg::*;

    logic [31:0] r_lo;
    logic [31:0] r_hi;
    logic [31:0] r_mix;
    logic [31:0] prod;

    // Only the low 32 bits of the product matter, so the partial product of the
    // multiplier's high half contributes only its low 16 bits shifted up.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_lo  <= 32'(i_code) * {16'd0, HASH_MUL[15:0]};
            r_hi  <= 32'(i_code) * {16'd0, HASH_MUL[31:16]};
            r_mix <= i_font ^ {24'd0, i_type};
        end
    end

    assign prod     = r_lo + {r_hi[15:0], 16'd0};
    assign o_bucket = BKT_W'(r_mix ^ prod);

endmodule

### design/hashed_chained_cache_with_bump_pool_core.sv
// Top level: chained hash glyph cache with a bump pool allocator.
//
//  channel  | dir | handshake          | payload
//  i_req    | in  | valid/ready        | command, key, header/dot bytes
//  o_rsp    | out | valid/ready        | status, offset, size, statistics
//  i_cfg    | in  | valid/ready        | pool_bytes_total
//
// A lookup or insert passes the hash and head states, then an entry read and key
// compare per chain entry visited and a last read that meets the chain end; a
// walk that ends on a hit skips that last read. Clear, stats and rejected requests
// go from the hash state to the result. After a transfer is accepted, ready stays
// low until the result is taken, and it returns in the cycle after that transfer.
// Reset clears the bucket valid bits, counters and pool; entries stay unset.
module hashed_chained_cache_with_bump_pool_core (
    input  logic i_clk,
    input  logic i_rst_n,
    hcc_req_if.sink   i_req,
    hcc_rsp_if.source o_rsp,
    hcc_cfg_if.sink   i_cfg
);
    import hcc_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_HASH  = 6'b000010,
        S_HEAD  = 6'b000100,
        S_READ  = 6'b001000,
        S_CMP   = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    t_req   r_req;
    t_rsp   r_rsp;

    logic [23:0] r_pool_total;
    logic [31:0] r_hits, r_misses;
    logic [23:0] r_used;
    logic [PTR_W-1:0] r_cnt;
    logic [BUCKETS-1:0] r_bvalid;
    logic [ENT_W-1:0] r_bhead [BUCKETS];
    logic [BKT_W-1:0] r_bkt;
    logic [PTR_W-1:0] r_ptr;
    logic [ENT_W-1:0] r_head;
    logic             r_head_ok;

    // Entry memory, one word per entry.
    localparam int unsigned EW = 32 + 21 + 8 + 24 + 17 + PTR_W;
    logic [EW-1:0] r_mem [MAX_ENTRIES];
    logic [EW-1:0] r_rd;
    logic [31:0] e_font;
    logic [20:0] e_code;
    logic [7:0]  e_type;
    logic [23:0] e_off;
    logic [16:0] e_size;
    logic [PTR_W-1:0] e_next;

    logic [BKT_W-1:0] hash_bkt;
    logic accept, key_eq, early_out;
    logic [16:0] total;
    logic [24:0] need;
    logic [23:0] rec_off;

    assign accept      = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign o_rsp.valid = (r_state == S_OUT);
    assign o_rsp.data  = r_rsp;

    hcc_hash u_hash (
        .i_clk    (i_clk),
        .i_start  (accept),
        .i_font   (i_req.data.font_id),
        .i_code   (i_req.data.code_point),
        .i_type   (i_req.data.glyph_type),
        .o_bucket (hash_bkt)
    );

    assign {e_font, e_code, e_type, e_off, e_size, e_next} = r_rd;
    assign key_eq  = (e_font == r_req.font_id) && (e_code == r_req.code_point)
                  && (e_type == r_req.glyph_type);
    assign total   = 17'(r_req.header_bytes) + 17'(r_req.dot_bytes);
    assign rec_off = r_used + REC_BYTES;
    assign need    = 25'(r_used) + 25'(REC_BYTES) + 25'((18'(total) + 18'd3) & ~18'd3);

    // Requests that finish without walking a chain.
    assign early_out = (r_pool_total == '0) || (t_cmd'(r_req.command) == CMD_CLEAR)
                    || (t_cmd'(r_req.command) == CMD_STATS)
                    || (t_cmd'(r_req.command) == CMD_INSERT && r_req.dot_bytes == '0);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (accept) n_state = S_HASH;
            S_HASH:  n_state = early_out ? S_OUT : S_HEAD;
            S_HEAD:  n_state = S_READ;
            S_READ:  n_state = (r_ptr == NIL) ? S_OUT : S_CMP;
            S_CMP:   n_state = (key_eq || r_ptr == NIL) ? S_OUT : S_READ;
            S_OUT:   if (o_rsp.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_READ && r_ptr != NIL) begin
            r_rd <= r_mem[r_ptr[ENT_W-1:0]];
        end
        if (r_state == S_READ && r_ptr == NIL && t_cmd'(r_req.command) == CMD_INSERT
                && r_pool_total != '0 && r_req.dot_bytes != '0
                && r_cnt != NIL && need <= 25'(r_pool_total)) begin
            r_mem[r_cnt[ENT_W-1:0]] <= {r_req.font_id, r_req.code_point, r_req.glyph_type,
                                        rec_off, total,
                                        r_head_ok ? PTR_W'(r_head) : NIL};
        end
        if (r_state == S_HEAD) begin
            r_head    <= r_bhead[hash_bkt];
            r_head_ok <= r_bvalid[hash_bkt];
        end
        if (accept) r_req <= i_req.data;
    end

    // Finishing writes all of the result, commits state updates.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pool_total <= '0;
            r_hits       <= '0;
            r_misses     <= '0;
            r_used       <= '0;
            r_cnt        <= '0;
            r_bvalid     <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) r_pool_total <= i_cfg.data;
            case (r_state)
                S_HASH: begin
                    if (early_out) begin
                        r_rsp.data_offset <= '0;
                        r_rsp.data_len    <= '0;
                        r_rsp.pool_bytes  <= r_pool_total;
                        if (t_cmd'(r_req.command) == CMD_STATS) begin
                            r_rsp.status        <= ST_DONE;
                            r_rsp.lookup_hits   <= r_hits;
                            r_rsp.lookup_misses <= r_misses;
                            r_rsp.used_bytes    <= r_used;
                        end else if (r_pool_total != '0 &&
                                     t_cmd'(r_req.command) == CMD_CLEAR) begin
                            r_rsp.status        <= ST_DONE;
                            r_rsp.lookup_hits   <= '0;
                            r_rsp.lookup_misses <= '0;
                            r_rsp.used_bytes    <= '0;
                            r_hits <= '0; r_misses <= '0; r_used <= '0;
                            r_cnt  <= '0; r_bvalid <= '0;
                        end else begin
                            r_rsp.status        <= ST_REJECTED;
                            r_rsp.lookup_hits   <= r_hits;
                            r_rsp.lookup_misses <= r_misses;
                            r_rsp.used_bytes    <= r_used;
                        end
                    end
                end
                S_HEAD: begin
                    r_bkt <= hash_bkt;
                    r_ptr <= r_bvalid[hash_bkt] ? PTR_W'(r_bhead[hash_bkt]) : NIL;
                end
                S_READ: begin
                    if (r_ptr == NIL) begin
                        r_rsp.pool_bytes  <= r_pool_total;
                        r_rsp.lookup_hits <= r_hits;
                        if (t_cmd'(r_req.command) == CMD_LOOKUP) begin
                            r_misses <= r_misses + 32'd1;
                            r_rsp.status        <= ST_MISS;
                            r_rsp.data_offset   <= '0;
                            r_rsp.data_len      <= '0;
                            r_rsp.lookup_misses <= r_misses + 32'd1;
                            r_rsp.used_bytes    <= r_used;
                        end else begin
                            r_rsp.lookup_misses <= r_misses;
                            if (r_cnt == NIL || need > 25'(r_pool_total)) begin
                                r_rsp.status      <= ST_NO_ROOM;
                                r_rsp.data_offset <= '0;
                                r_rsp.data_len    <= '0;
                                r_rsp.used_bytes  <= r_used;
                            end else begin
                                r_rsp.status      <= ST_INSERTED;
                                r_rsp.data_offset <= rec_off;
                                r_rsp.data_len    <= total;
                                r_rsp.used_bytes  <= need[23:0];
                                r_used   <= need[23:0];
                                r_cnt    <= r_cnt + PTR_W'(1);
                                r_bvalid[r_bkt] <= 1'b1;
                            end
                        end
                    end
                end
                S_CMP: begin
                    if (key_eq) begin
                        r_rsp.pool_bytes    <= r_pool_total;
                        r_rsp.data_offset   <= e_off;
                        r_rsp.data_len      <= e_size;
                        r_rsp.lookup_misses <= r_misses;
                        r_rsp.used_bytes    <= r_used;
                        if (t_cmd'(r_req.command) == CMD_LOOKUP) begin
                            r_hits <= r_hits + 32'd1;
                            r_rsp.status      <= ST_HIT;
                            r_rsp.lookup_hits <= r_hits + 32'd1;
                        end else begin
                            r_rsp.status      <= ST_PRESENT;
                            r_rsp.lookup_hits <= r_hits;
                        end
                    end else begin
                        r_ptr <= e_next;
                    end
                end
                default: ;
            endcase
        end
    end

    // Bucket heads: plain registers written at the chain insert.
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ && r_ptr == NIL && t_cmd'(r_req.command) == CMD_INSERT
                && r_cnt != NIL && need <= 25'(r_pool_total)) begin
            r_bhead[r_bkt] <= r_cnt[ENT_W-1:0];
        end
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> !o_rsp.valid)
        else $error("ready while a result is pending");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= NIL)
        else $error("entry count past store size");
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ready) |=> (o_rsp.valid && $stable(o_rsp.data)))
        else $error("result changed while stalled");
    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_state == S_READ) && r_state == S_OUT
            && o_rsp.data.status == ST_INSERTED
        |-> 25'(r_used) <= 25'(r_pool_total))
        else $error("allocation past pool size");

endmodule

### test/hcc_test_if.sv
// Testbench package: constants shared by the test.
`timescale 1ns / 100ps
package hcc_test_pkg;
    import hcc_pkg::*;
    localparam logic [23:0] POOL_MAX = 24'hFFFFFF;
endpackage

### test/hashed_chained_cache_with_bump_pool_core_test.sv
// Testbench for the glyph cache: directed and random requests checked against a predictor.
`timescale 1ns / 100ps
module hashed_chained_cache_with_bump_pool_core_test;
    import hcc_pkg::*;
    import hcc_test_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    hcc_req_if req_ch();
    hcc_rsp_if rsp_ch();
    hcc_cfg_if cfg_ch();

    hashed_chained_cache_with_bump_pool_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_ch.sink), .o_rsp(rsp_ch.source),
        .i_cfg(cfg_ch.sink)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state of the cache.
    logic [23:0] pool_limit;
    logic [PTR_W-1:0] chain_head [BUCKETS];
    logic [31:0] key_font [MAX_ENTRIES];
    logic [20:0] key_code [MAX_ENTRIES];
    logic [7:0]  key_type [MAX_ENTRIES];
    logic [23:0] ent_offset [MAX_ENTRIES];
    logic [16:0] ent_size [MAX_ENTRIES];
    logic [PTR_W-1:0] ent_next [MAX_ENTRIES];
    int unsigned n_entries;
    logic [23:0] pool_fill;
    logic [31:0] hit_total, miss_total;

    t_rsp pending_rsp[$];
    int   errors = 0;
    bit   rsp_stall_on = 1'b1;
    // Keys recently inserted, reused so that lookups hit.
    t_req known_keys[$];

    function automatic void flush_cache();
        for (int i = 0; i < BUCKETS; i++) chain_head[i] = NIL;
        n_entries = 0;
        pool_fill = '0;
        hit_total = '0;
        miss_total = '0;
    endfunction

    function automatic int find_glyph(t_req r);
        logic [31:0] h;
        logic [PTR_W-1:0] e;
        h = r.font_id ^ (32'(r.code_point) * HASH_MUL) ^ 32'(r.glyph_type);
        e = chain_head[h % BUCKETS];
        while (e != NIL) begin
            if (key_font[e] == r.font_id && key_code[e] == r.code_point &&
                key_type[e] == r.glyph_type) return int'(e);
            e = ent_next[e];
        end
        return -1;
    endfunction

    function automatic t_rsp predict_glyph(t_req r);
        t_rsp o;
        int e;
        logic [31:0] h, total, need;
        o = '0;
        o.status = ST_REJECTED;
        h = r.font_id ^ (32'(r.code_point) * HASH_MUL) ^ 32'(r.glyph_type);
        case (t_cmd'(r.command))
            CMD_LOOKUP: if (pool_limit != 0) begin
                e = find_glyph(r);
                if (e >= 0) begin
                    hit_total++;
                    o.status = ST_HIT;
                    o.data_offset = ent_offset[e];
                    o.data_len = ent_size[e];
                end else begin
                    miss_total++;
                    o.status = ST_MISS;
                end
            end
            CMD_INSERT: if (pool_limit != 0 && r.dot_bytes != 0) begin
                e = find_glyph(r);
                total = 32'(r.header_bytes) + 32'(r.dot_bytes);
                if (e >= 0) begin
                    o.status = ST_PRESENT;
                    o.data_offset = ent_offset[e];
                    o.data_len = ent_size[e];
                end else begin
                    need = 32'(pool_fill) + 32'(REC_BYTES) + ((total + 3) & ~32'd3);
                    if (n_entries >= MAX_ENTRIES || need > 32'(pool_limit)) begin
                        o.status = ST_NO_ROOM;
                    end else begin
                        key_font[n_entries] = r.font_id;
                        key_code[n_entries] = r.code_point;
                        key_type[n_entries] = r.glyph_type;
                        ent_offset[n_entries] = pool_fill + REC_BYTES;
                        ent_size[n_entries] = 17'(total);
                        ent_next[n_entries] = chain_head[h % BUCKETS];
                        chain_head[h % BUCKETS] = PTR_W'(n_entries);
                        o.data_offset = ent_offset[n_entries];
                        o.data_len = 17'(total);
                        n_entries++;
                        pool_fill = 24'(need);
                        o.status = ST_INSERTED;
                    end
                end
            end
            CMD_CLEAR: if (pool_limit != 0) begin
                flush_cache();
                o.status = ST_DONE;
            end
            default: o.status = ST_DONE;
        endcase
        o.lookup_hits = hit_total;
        o.lookup_misses = miss_total;
        o.used_bytes = pool_fill;
        o.pool_bytes = pool_limit;
        return o;
    endfunction

    initial begin
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        rsp_ch.ready = 1'b0;
        pool_limit = '0;
        flush_cache();
    end

    // Result checker with its own stall pattern.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (pending_rsp.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, rsp_ch.data);
                    errors++;
                end else begin
                    t_rsp x;
                    x = pending_rsp.pop_front();
                    if (x.status != rsp_ch.data.status ||
                        x.data_offset != rsp_ch.data.data_offset ||
                        x.data_len != rsp_ch.data.data_len ||
                        x.lookup_hits != rsp_ch.data.lookup_hits ||
                        x.lookup_misses != rsp_ch.data.lookup_misses ||
                        x.used_bytes != rsp_ch.data.used_bytes ||
                        x.pool_bytes != rsp_ch.data.pool_bytes) begin
                        $display("%0t: mismatch expected %p actual %p", $time, x,
                                 rsp_ch.data);
                        errors++;
                    end
                end
            end
            rsp_ch.ready <= !rsp_stall_on || ($urandom_range(0, 3) != 0);
        end
    end

    task automatic send_glyph_request(t_req r);
        req_ch.valid <= 1'b1;
        req_ch.data <= r;
        do @(posedge i_clk); while (!req_ch.ready);
        pending_rsp.push_back(predict_glyph(r));
        if (r.command == CMD_INSERT) known_keys.push_back(r);
        if (known_keys.size() > 64) void'(known_keys.pop_front());
        // Burst gaps: sometimes keep valid high for the next transfer.
        if ($urandom_range(0, 2) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_pool_limit(logic [23:0] v);
        drain_results();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        pool_limit = v;
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_req make_glyph(t_cmd c);
        t_req r;
        r.command = c;
        r.font_id = $urandom_range(0, 3) == 0 ? $urandom() : 32'($urandom_range(0, 7));
        r.code_point = $urandom_range(0, 3) == 0 ? 21'($urandom_range(0, 1114111))
                                                 : 21'($urandom_range(32, 160));
        r.glyph_type = $urandom_range(0, 3) == 0 ? 8'($urandom()) : 8'($urandom_range(0, 2));
        r.header_bytes = $urandom_range(0, 7) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 40));
        r.dot_bytes = $urandom_range(0, 7) == 0 ? 16'($urandom()) : 16'($urandom_range(0, 300));
        return r;
    endfunction

    task automatic test_not_ready();
        for (int c = 0; c < 4; c++) send_glyph_request(make_glyph(t_cmd'(c)));
    endtask

    task automatic test_directed();
        t_req r;
        write_pool_limit(POOL_MAX);
        r = '{CMD_INSERT, 32'hFFFFFFFF, 21'd1114111, 8'hFF, 16'hFFFF, 16'hFFFF};
        send_glyph_request(r);
        send_glyph_request(r);
        r.command = CMD_LOOKUP;
        send_glyph_request(r);
        r = '{CMD_INSERT, 32'd0, 21'd0, 8'd0, 16'd0, 16'd0};
        send_glyph_request(r);
        r.dot_bytes = 16'd1;
        send_glyph_request(r);
        r.command = CMD_LOOKUP;
        send_glyph_request(r);
        r.font_id = 32'd64;
        send_glyph_request(r);
        send_glyph_request(make_glyph(CMD_STATS));
        // Shrink the pool below what is used: inserts now fail.
        write_pool_limit(24'd100);
        send_glyph_request(make_glyph(CMD_INSERT));
        send_glyph_request(make_glyph(CMD_CLEAR));
        write_pool_limit(24'd60);
        r = '{CMD_INSERT, 32'd5, 21'd65, 8'd1, 16'd4, 16'd8};
        send_glyph_request(r);
        r.code_point = 21'd66;
        send_glyph_request(r);
        r.command = CMD_LOOKUP;
        send_glyph_request(r);
    endtask

    task automatic test_random(int count, bit stalls);
        t_req r;
        rsp_stall_on = stalls;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 19))
                0: r = make_glyph(CMD_CLEAR);
                1: r = make_glyph(CMD_STATS);
                2, 3, 4, 5, 6, 7: r = make_glyph(CMD_INSERT);
                default: begin
                    r = make_glyph(CMD_LOOKUP);
                    if (known_keys.size() != 0 && $urandom_range(0, 1)) begin
                        r = known_keys[$urandom_range(0, known_keys.size() - 1)];
                        r.command = $urandom_range(0, 3) == 0 ? CMD_INSERT : CMD_LOOKUP;
                    end
                end
            endcase
            send_glyph_request(r);
        end
        rsp_stall_on = 1'b1;
    endtask

    // Fill the entry store beyond its capacity with tiny entries.
    task automatic test_store_full();
        t_req r;
        write_pool_limit(POOL_MAX);
        send_glyph_request(make_glyph(CMD_CLEAR));
        for (int i = 0; i < MAX_ENTRIES + 4; i++) begin
            r = '{CMD_INSERT, 32'(i), 21'd7, 8'd0, 16'd0, 16'd1};
            send_glyph_request(r);
        end
        r.command = CMD_LOOKUP;
        send_glyph_request(r);
        send_glyph_request(make_glyph(CMD_CLEAR));
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_not_ready();
        test_directed();
        write_pool_limit(24'd4000);
        test_random(200, 1'b1);
        write_pool_limit(24'd1);
        test_random(60, 1'b0);
        write_pool_limit(24'($urandom_range(2, POOL_MAX)));
        test_random(200, 1'b1);
        test_store_full();
        write_pool_limit(24'd0);
        test_random(40, 1'b1);
        write_pool_limit(24'd20000);
        test_random(150, 1'b0);
        drain_results();
        if (errors == 0) begin
            $display("hashed_chained_cache_with_bump_pool_core_test passed");
        end else begin
            $display("hashed_chained_cache_with_bump_pool_core_test failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("hashed_chained_cache_with_bump_pool_core_test failed");
        $finish;
    end
endmodule

### hashed_chained_cache_with_bump_pool_core.f
design/hcc_pkg.sv
design/hcc_if.sv
design/hcc_hash.sv
design/hashed_chained_cache_with_bump_pool_core.sv
test/hcc_test_if.sv
test/hashed_chained_cache_with_bump_pool_core_test.sv
